// ===== hw/rtl/ztc_pkg.sv =====
// ============================================================================
// ztc_pkg
// Shared constants, types and memory request structs for the zero tile
// compactor.
// ============================================================================
`default_nettype none

package ztc_pkg;

	// Systolic array edge; a tile is ARRAY_SIZE rows of ARRAY_SIZE/4 words.
	localparam int ARRAY_SIZE = 16;
	localparam int ROW_WORDS  = ARRAY_SIZE / 4;
	localparam int TILE_WORDS = ARRAY_SIZE * ROW_WORDS;
	localparam int BUF_DEPTH  = 64;
	localparam int ADDR_W     = $clog2(BUF_DEPTH);
	localparam int WORD_W     = 32;
	localparam int COUNT_W    = 20;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	// Index of the final word of a tile.
	localparam addr_t LAST_POS = addr_t'(TILE_WORDS - 1);

	typedef struct packed {
		logic  en;
		addr_t addr;
		word_t data;
	} ram_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} ram_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ztc_stream_if.sv =====
// ============================================================================
// ztc_stream_if
// Valid/ready channels for weight words in and kept words out.
// ============================================================================
`default_nettype none

interface ztc_in_if
	import ztc_pkg::*;
();
	logic  valid;
	logic  ready;
	word_t weight_word;

	modport source (output valid, output weight_word, input ready);
	modport sink (input valid, input weight_word, output ready);
endinterface

interface ztc_out_if
	import ztc_pkg::*;
();
	logic  valid;
	logic  ready;
	word_t kept_word;
	logic  tile_end;

	modport source (output valid, output kept_word, output tile_end, input ready);
	modport sink (input valid, input kept_word, input tile_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/zero_tile_compactor.sv =====
// ============================================================================
// zero_tile_compactor
// Removes all-zero tiles from a tile-major stream of packed weight words.
// ============================================================================
// Weight words are accepted one per cycle, except during a replay, and
// written into a 64-entry tile buffer while the sequencer notes whether any
// word of the tile is nonzero. A tile is ARRAY_SIZE rows of ARRAY_SIZE/4
// words (TILE_WORDS words). When its last word arrives, an all-zero tile is
// dropped and filling goes straight on. A tile with a nonzero word is replayed
// from the buffer's single read port, one word per cycle unless the output
// stalls, with tile_end on its final word; input ready is low during the
// replay. The buffer's registered read data is the output register, so the
// next tile may start filling while the final replayed word waits to be
// taken. Only the first tile_count tiles are processed; later words are
// accepted and discarded. Write tile_count only while the block is idle.
// There is no clearing pass after reset.
`default_nettype none

module zero_tile_compactor
	import ztc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire count_t cfg_wdata,
	ztc_in_if.sink      in,
	ztc_out_if.source   out
);

	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	word_t   rdata;
	logic    in_ready;
	logic    out_valid;
	logic    out_end;

	// Sequencer: owns position, nonzero flag, tile count and replay pointer.
	ztc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in.valid),
		.in_word   (in.weight_word),
		.in_ready  (in_ready),
		.out_ready (out.ready),
		.out_valid (out_valid),
		.out_end   (out_end),
		.ram_wr    (ram_wr),
		.ram_rd    (ram_rd)
	);

	// Tile buffer; its read register holds the word on offer at the output.
	ztc_tile_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.rd    (ram_rd),
		.rdata (rdata)
	);

	assign in.ready      = in_ready;
	assign out.valid     = out_valid;
	assign out.kept_word = rdata;
	assign out.tile_end  = out_end;

	// Fill and replay never touch the buffer in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr.en && ram_rd.en))
		else $error("tile buffer written and read in the same cycle");

	// A read must not overwrite a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.en |-> (!out.valid || out.ready))
		else $error("replay read clobbers a pending output transaction");

	// Every issued read is offered at the output on the next cycle.
	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.en |=> out.valid)
		else $error("replay read not presented at the output");

	// Input is stalled while a replay is reading the buffer.
	a_stall_on_replay: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd.en |-> !in.ready)
		else $error("input ready during tile replay");

endmodule

`default_nettype wire

// ===== hw/rtl/ztc_tile_ram.sv =====
// ============================================================================
// ztc_tile_ram
// Tile buffer: one write port, one read port, registered read data that holds
// when no read is issued.
// ============================================================================
`default_nettype none

module ztc_tile_ram
	import ztc_pkg::*;
(
	input  wire logic    clk,
	input  wire ram_wr_t wr,
	input  wire ram_rd_t rd,
	output      word_t   rdata
);

	word_t mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ztc_seq.sv =====
// ============================================================================
// ztc_seq
// Fill and replay sequencer: tracks tile position, nonzero flag and tile
// count, and drives the tile buffer ports.
// ============================================================================
`default_nettype none

module ztc_seq
	import ztc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_we,
	input  wire count_t  cfg_wdata,
	input  wire logic    in_valid,
	input  wire word_t   in_word,
	output      logic    in_ready,
	input  wire logic    out_ready,
	output      logic    out_valid,
	output      logic    out_end,
	output      ram_wr_t ram_wr,
	output      ram_rd_t ram_rd
);

	localparam logic ST_FILL   = 1'b0;
	localparam logic ST_REPLAY = 1'b1;

	logic   state_q;
	addr_t  pos_q;
	addr_t  rd_cnt_q;
	logic   nz_q;
	count_t tiles_seen_q;
	count_t tile_count_q;
	logic   out_valid_q;
	logic   out_end_q;

	logic accept;
	logic live;
	logic store;
	logic nz_next;
	logic last_word;
	logic issue;

	assign in_ready  = (state_q == ST_FILL);
	assign accept    = in_valid && in_ready;
	assign live      = (tiles_seen_q < tile_count_q);
	assign store     = accept && live;
	assign nz_next   = nz_q || (in_word != '0);
	assign last_word = (pos_q == LAST_POS);
	// Issue a read only when the output register is empty or being drained.
	assign issue     = (state_q == ST_REPLAY) && (!out_valid_q || out_ready);

	always_comb begin
		ram_wr.en   = store;
		ram_wr.addr = pos_q;
		ram_wr.data = in_word;
		ram_rd.en   = issue;
		ram_rd.addr = rd_cnt_q;
	end

	assign out_valid = out_valid_q;
	assign out_end   = out_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_count_q <= '0;
		end else if (cfg_we) begin
			tile_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_FILL;
			pos_q        <= '0;
			rd_cnt_q     <= '0;
			nz_q         <= 1'b0;
			tiles_seen_q <= '0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (store) begin
						if (last_word) begin
							pos_q        <= '0;
							nz_q         <= 1'b0;
							tiles_seen_q <= tiles_seen_q + 1'b1;
							rd_cnt_q     <= '0;
							if (nz_next) begin
								state_q <= ST_REPLAY;
							end
						end else begin
							pos_q <= pos_q + 1'b1;
							nz_q  <= nz_next;
						end
					end
				end
				ST_REPLAY: begin
					if (issue) begin
						if (rd_cnt_q == LAST_POS) begin
							rd_cnt_q <= '0;
							state_q  <= ST_FILL;
						end else begin
							rd_cnt_q <= rd_cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_FILL;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (issue) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_end_q <= (rd_cnt_q == LAST_POS);
		end
	end

endmodule

`default_nettype wire
